[rtl/core/pgpg_pkg.sv]
// ----------------------------------------------------------------------------
// Polar Gaussian pair generator package
// Shared constants and the stage payload types of the datapath.
// ----------------------------------------------------------------------------
package pgpg_pkg;

    // Uniform input resolution and fraction bits of the output deviate.
    localparam int UNIFORM_BITS  = 32;
    localparam int OUT_FRAC_BITS = 26;

    // Iteration counts of the logarithm/divider and square root pipelines.
    localparam int LOG_STEPS  = 32;
    localparam int SQRT_STEPS = 32;

    // 2 ln 2 in Q1.31.
    localparam logic [31:0] TWO_LN2_Q31 = 32'hB17217F8;
    // One half in Q0.32, the offset that centers a uniform sample.
    localparam logic [31:0] HALF_Q31    = 32'h8000_0000;
    // Radius one in Q2.62.
    localparam logic [63:0] S_ONE       = 64'h4000_0000_0000_0000;
    // Keeps the valid bits of a uniform sample.
    localparam logic [63:0] UNI_MASK    = (UNIFORM_BITS >= 64) ? {64{1'b1}} :
                                          ((64'd1 << UNIFORM_BITS) - 64'd1);

    // Payload of the logarithm and ratio pipeline.
    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [5:0]  p;
        logic [31:0] m;
        logic [31:0] f;
        logic [62:0] den;
        logic [62:0] rem1;
        logic [62:0] rem2;
        logic [32:0] q1;
        logic [32:0] q2;
    } t_ld;

    // Squared deviates, ready for the square root.
    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [63:0] v1;
        logic [63:0] v2;
    } t_vv;

    // Payload of the square root pipeline.
    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] r1;
        logic [63:0] r2;
    } t_sq;

    // Finished magnitudes handed to the output stage.
    typedef struct packed {
        logic        vld;
        logic        n1;
        logic        n2;
        logic [32:0] r1;
        logic [32:0] r2;
    } t_root;

endpackage

[rtl/core/pgpg_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Centers the uniforms, forms the radius, rejects, normalizes, starts division.
// ----------------------------------------------------------------------------
module pgpg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [31:0]    i_first_uniform,
    input  logic [31:0]    i_second_uniform,
    output logic           o_vld,
    output pgpg_pkg::t_ld  o_ld
);

    // Returns {negative, magnitude} of 2r - 1 in Q1.31.
    function automatic logic [32:0] align(input logic [31:0] r);
        logic [63:0] w;
        logic [31:0] ra;
        w = {32'd0, r} & pgpg_pkg::UNI_MASK;
        if (pgpg_pkg::UNIFORM_BITS >= 32) begin
            w = w >> (pgpg_pkg::UNIFORM_BITS - 32);
        end else begin
            w = w << (32 - pgpg_pkg::UNIFORM_BITS);
        end
        ra = w[31:0];
        if (ra[31]) begin
            align = {1'b0, 1'b0, ra[30:0]};
        end else begin
            align = {1'b1, pgpg_pkg::HALF_Q31 - ra};
        end
    endfunction

    logic [4:0]  r_vld;
    logic [32:0] n_al1, n_al2;
    logic [31:0] r_a1, r_a2;
    logic [1:0]  r_n0, r_n1, r_n2, r_n3;
    logic [62:0] r_sq1, r_sq2, r_sq1b, r_sq2b, r_sq1c, r_sq2c;
    logic [63:0] n_s;
    logic        n_ok;
    logic [62:0] r_s, r_s3;
    logic [63:0] n_sw;
    logic [3:0]  n_nz, r_nz;
    logic [3:0]  n_pos [4];
    logic [3:0]  r_pos [4];
    logic [5:0]  n_p;
    logic [63:0] n_sh;
    pgpg_pkg::t_ld n_ld;

    assign n_al1 = align(i_first_uniform);
    assign n_al2 = align(i_second_uniform);

    assign n_s  = {1'b0, r_sq1} + {1'b0, r_sq2};
    assign n_ok = (n_s != 64'd0) && (n_s <= pgpg_pkg::S_ONE);
    assign n_sw = {1'b0, r_s};

    // Leading one per 16-bit chunk.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_nz[c]  = 1'b0;
            n_pos[c] = 4'd0;
            for (int b = 0; b < 16; b++) begin
                if (n_sw[c*16 + b]) begin
                    n_nz[c]  = 1'b1;
                    n_pos[c] = 4'(b);
                end
            end
        end
    end

    // Top bit index, mantissa and the first quotient bit.
    always_comb begin
        n_p = 6'd0;
        for (int c = 0; c < 4; c++) begin
            if (r_nz[c]) begin
                n_p = {2'(c), r_pos[c]};
            end
        end
        n_sh      = {1'b0, r_s3} << (6'd63 - n_p);
        n_ld.n1   = r_n3[0];
        n_ld.n2   = r_n3[1];
        n_ld.p    = n_p;
        n_ld.m    = n_sh[63:32];
        n_ld.f    = 32'd0;
        n_ld.den  = r_s3;
        if (r_sq1c >= r_s3) begin
            n_ld.rem1 = r_sq1c - r_s3;
            n_ld.q1   = 33'd1;
        end else begin
            n_ld.rem1 = r_sq1c;
            n_ld.q1   = 33'd0;
        end
        if (r_sq2c >= r_s3) begin
            n_ld.rem2 = r_sq2c - r_s3;
            n_ld.q2   = 33'd1;
        end else begin
            n_ld.rem2 = r_sq2c;
            n_ld.q2   = 33'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else if (i_en) begin
            r_vld <= {r_vld[3], r_vld[2], r_vld[1] & n_ok, r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1   <= n_al1[31:0];
            r_a2   <= n_al2[31:0];
            r_n0   <= {n_al2[32], n_al1[32]};
            r_sq1  <= 63'(r_a1 * r_a1);
            r_sq2  <= 63'(r_a2 * r_a2);
            r_n1   <= r_n0;
            r_s    <= n_s[62:0];
            r_sq1b <= r_sq1;
            r_sq2b <= r_sq2;
            r_n2   <= r_n1;
            r_nz   <= n_nz;
            r_pos  <= n_pos;
            r_s3   <= r_s;
            r_sq1c <= r_sq1b;
            r_sq2c <= r_sq2b;
            r_n3   <= r_n2;
            o_ld   <= n_ld;
        end
    end

    assign o_vld = r_vld[4];

endmodule

[rtl/core/pgpg_logdiv.sv]
// ----------------------------------------------------------------------------
// Logarithm and ratio pipeline
// Each stage does one squaring step of log2 and one quotient bit per lane.
// ----------------------------------------------------------------------------
module pgpg_logdiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  pgpg_pkg::t_ld  i_ld,
    output logic           o_vld,
    output pgpg_pkg::t_ld  o_ld
);

    localparam int N = pgpg_pkg::LOG_STEPS;

    // Returns {remainder, quotient} after one restoring step.
    function automatic logic [95:0] dstep(input logic [62:0] rem, input logic [62:0] den,
                                          input logic [32:0] q);
        logic [63:0] ra;
        ra = {rem, 1'b0};
        if (ra >= {1'b0, den}) begin
            dstep = {63'(ra - {1'b0, den}), q[31:0], 1'b1};
        end else begin
            dstep = {ra[62:0], q[31:0], 1'b0};
        end
    endfunction

    function automatic pgpg_pkg::t_ld step(input pgpg_pkg::t_ld x);
        pgpg_pkg::t_ld y;
        logic [63:0]   mm;
        logic [95:0]   d1, d2;
        y  = x;
        mm = x.m * x.m;
        if (mm[63]) begin
            y.m = mm[63:32];
            y.f = {x.f[30:0], 1'b1};
        end else begin
            y.m = mm[62:31];
            y.f = {x.f[30:0], 1'b0};
        end
        d1     = dstep(x.rem1, x.den, x.q1);
        d2     = dstep(x.rem2, x.den, x.q2);
        y.rem1 = d1[95:33];
        y.q1   = d1[32:0];
        y.rem2 = d2[95:33];
        y.q2   = d2[32:0];
        step   = y;
    endfunction

    logic [N-1:0]  r_vld;
    pgpg_pkg::t_ld r_st [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= step(i_ld);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= step(r_st[k-1]);
                end
            end
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_ld  = r_st[N-1];

endmodule

[rtl/core/pgpg_scale.sv]
// ----------------------------------------------------------------------------
// Scale stages
// Forms -2 ln s in Q32 and multiplies it into each ratio to give v in Q56.
// ----------------------------------------------------------------------------
module pgpg_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  pgpg_pkg::t_ld  i_ld,
    output logic           o_vld,
    output pgpg_pkg::t_vv  o_vv
);

    logic [4:0]  r_vld;
    logic [1:0]  r_n0, r_n1, r_n2, r_n3;
    logic [37:0] r_nl;
    logic [32:0] r_q1a, r_q2a, r_q1b, r_q2b, r_q1c, r_q2c;
    logic [37:0] r_ph;
    logic [63:0] r_pl;
    logic [39:0] r_lq;
    logic [40:0] r_h1, r_h2;
    logic [64:0] r_l1, r_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // -log2(s) in Q32.
            r_nl  <= {6'd62 - i_ld.p, 32'd0} - {6'd0, i_ld.f};
            r_q1a <= i_ld.q1;
            r_q2a <= i_ld.q2;
            r_n0  <= {i_ld.n2, i_ld.n1};
            // Times 2 ln 2, integer and fraction parts apart.
            r_ph  <= r_nl[37:32] * pgpg_pkg::TWO_LN2_Q31;
            r_pl  <= r_nl[31:0] * pgpg_pkg::TWO_LN2_Q31;
            r_q1b <= r_q1a;
            r_q2b <= r_q2a;
            r_n1  <= r_n0;
            r_lq  <= {1'b0, r_ph, 1'b0} + 40'(r_pl[63:31]);
            r_q1c <= r_q1b;
            r_q2c <= r_q2b;
            r_n2  <= r_n1;
            r_h1  <= r_q1c * r_lq[39:32];
            r_l1  <= r_q1c * r_lq[31:0];
            r_h2  <= r_q2c * r_lq[39:32];
            r_l2  <= r_q2c * r_lq[31:0];
            r_n3  <= r_n2;
            o_vv.v1 <= (64'(r_h1) << 24) + 64'(r_l1 >> 8);
            o_vv.v2 <= (64'(r_h2) << 24) + 64'(r_l2 >> 8);
            o_vv.n1 <= r_n3[0];
            o_vv.n2 <= r_n3[1];
        end
    end

    assign o_vld = r_vld[4];

endmodule

[rtl/core/pgpg_sqrt.sv]
// ----------------------------------------------------------------------------
// Square root pipeline
// One result bit per stage for both lanes, restoring method.
// ----------------------------------------------------------------------------
module pgpg_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  pgpg_pkg::t_vv    i_vv,
    output pgpg_pkg::t_root  o_root
);

    localparam int N = pgpg_pkg::SQRT_STEPS;

    // Returns {remainder, root} after the step with trial bit b.
    function automatic logic [127:0] lane(input logic [63:0] v, input logic [63:0] r,
                                          input logic [63:0] b);
        logic [63:0] t;
        t = r + b;
        if (v >= t) begin
            lane = {v - t, (r >> 1) + b};
        end else begin
            lane = {v, r >> 1};
        end
    endfunction

    function automatic pgpg_pkg::t_sq step(input pgpg_pkg::t_sq x, input logic [63:0] b);
        pgpg_pkg::t_sq y;
        logic [127:0]  l1, l2;
        y    = x;
        l1   = lane(x.v1, x.r1, b);
        l2   = lane(x.v2, x.r2, b);
        y.v1 = l1[127:64];
        y.r1 = l1[63:0];
        y.v2 = l2[127:64];
        y.r2 = l2[63:0];
        step = y;
    endfunction

    logic [N-1:0]  r_vld;
    pgpg_pkg::t_sq r_st [N];
    pgpg_pkg::t_sq n_in;

    always_comb begin
        n_in.n1 = i_vv.n1;
        n_in.n2 = i_vv.n2;
        n_in.v1 = i_vv.v1;
        n_in.v2 = i_vv.v2;
        n_in.r1 = 64'd0;
        n_in.r2 = 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2*N - 2 - 2*k);
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= step(n_in, BIT);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= step(r_st[k-1], BIT);
                end
            end
        end
    end

    assign o_root.vld = r_vld[N-1];
    assign o_root.n1  = r_st[N-1].n1;
    assign o_root.n2  = r_st[N-1].n2;
    assign o_root.r1  = r_st[N-1].r1[32:0];
    assign o_root.r2  = r_st[N-1].r2[32:0];

endmodule

[rtl/core/pgpg_out.sv]
// ----------------------------------------------------------------------------
// Output stage
// Applies sign and saturation, holds a pair and sends it as two beats.
// ----------------------------------------------------------------------------
module pgpg_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgpg_pkg::t_root    i_root,
    input  logic               i_ready,
    output logic               o_take,
    output logic               o_valid,
    output logic signed [31:0] o_gaussian_value,
    output logic               o_last_of_pair
);

    function automatic logic [31:0] fmt(input logic neg, input logic [32:0] r);
        logic [63:0] mag;
        mag = {31'd0, r};
        if (pgpg_pkg::OUT_FRAC_BITS >= 28) begin
            mag = mag << (pgpg_pkg::OUT_FRAC_BITS - 28);
        end else begin
            mag = mag >> (28 - pgpg_pkg::OUT_FRAC_BITS);
        end
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
            end
            fmt = 32'(64'd0 - mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                mag = 64'h7FFF_FFFF;
            end
            fmt = mag[31:0];
        end
    endfunction

    logic        r_ov;
    logic        r_ph;
    logic [31:0] r_x1, r_x2;

    // A new pair may load when the holder is empty or its second beat leaves.
    assign o_take = !r_ov || (r_ph && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ph <= 1'b0;
        end else if (o_take) begin
            r_ov <= i_root.vld;
            r_ph <= 1'b0;
        end else if (i_ready) begin
            r_ph <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_x1 <= fmt(i_root.n1, i_root.r1);
            r_x2 <= fmt(i_root.n2, i_root.r2);
        end
    end

    assign o_valid          = r_ov;
    assign o_last_of_pair   = r_ph;
    assign o_gaussian_value = r_ph ? r_x2 : r_x1;

endmodule

[rtl/core/polar_gaussian_pair_generator.sv]
// Flow: the first deviate of a pair is shown once its input beat has passed
// every stage; the second follows as soon as the first beat is taken.
// Throughput: one input beat per cycle while o_ready is high, one output
// beat per cycle while i_ready is high; the output port sets the pair rate.
// Rejected pairs leave a bubble and produce no output beat.
// Reset: synchronous, active low; clears all valid bits and the output holder.
// ----------------------------------------------------------------------------
// Polar Gaussian pair generator
// Marsaglia polar method in fixed point: two uniforms in, zero or two
// standard normal deviates out in Q5.26.
// ----------------------------------------------------------------------------
//
// The datapath is one pipeline that moves on a single enable. The enable is
// high whenever the last stage is empty or the output holder can take its
// pair, so a stall freezes every stage at once and nothing is lost or
// repeated. Valid bits travel with the data; a pair whose radius is zero or
// above one loses its valid bit right after the radius is formed.
//
// Stages:
//   front  : centering, squares, radius and reject, leading one search,
//            normalization and the first quotient bit (5 stages).
//   logdiv : 32 stages, each one squaring step of log2 and one quotient bit
//            of u1^2/s and u2^2/s.
//   scale  : -2 ln s in Q32 and its product with each ratio (5 stages).
//   sqrt   : 32 stages, one root bit per stage for both lanes.
//   out    : sign and saturation into a pair holder that sends the first
//            deviate, then the second marked as last.
module polar_gaussian_pair_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_first_uniform,
    input  logic [31:0]        i_second_uniform,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_gaussian_value,
    output logic               o_last_of_pair
);

    logic            en;
    logic            take;
    logic            fr_vld;
    pgpg_pkg::t_ld   fr_ld;
    logic            ld_vld;
    pgpg_pkg::t_ld   ld_ld;
    logic            sc_vld;
    pgpg_pkg::t_vv   sc_vv;
    pgpg_pkg::t_root root;

    // The whole pipeline advances unless a finished pair is waiting on the
    // output holder.
    assign en      = take || !root.vld;
    assign o_ready = en;

    pgpg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_vld            (i_valid),
        .i_first_uniform  (i_first_uniform),
        .i_second_uniform (i_second_uniform),
        .o_vld            (fr_vld),
        .o_ld             (fr_ld)
    );

    pgpg_logdiv u_logdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_ld    (fr_ld),
        .o_vld   (ld_vld),
        .o_ld    (ld_ld)
    );

    pgpg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (ld_vld),
        .i_ld    (ld_ld),
        .o_vld   (sc_vld),
        .o_vv    (sc_vv)
    );

    pgpg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sc_vld),
        .i_vv    (sc_vv),
        .o_root  (root)
    );

    pgpg_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_root           (root),
        .i_ready          (i_ready),
        .o_take           (take),
        .o_valid          (o_valid),
        .o_gaussian_value (o_gaussian_value),
        .o_last_of_pair   (o_last_of_pair)
    );

endmodule

[rtl/core/pgpg_chk.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the output beats of the generator for stall hold, pair ordering and reset.
// ----------------------------------------------------------------------------
module pgpg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_gaussian_value,
    input logic        o_last_of_pair
);

    // A stalled output beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gaussian_value)
                                && $stable(o_last_of_pair))
        else $error("output beat changed while stalled");

    // The first deviate of a pair is always followed by its second.
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_pair |=> o_valid && o_last_of_pair)
        else $error("second deviate missing after first");

    // After a last beat the next pair starts with a first beat.
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_of_pair |=> !o_last_of_pair)
        else $error("pair did not restart with a first deviate");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind polar_gaussian_pair_generator pgpg_chk u_pgpg_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_gaussian_value (o_gaussian_value),
    .o_last_of_pair   (o_last_of_pair)
);
